@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/pida_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pida_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned IDX_W       = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned MAX_RESULTS = 16;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_OUT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 3'd0,
    CMD_APPEND  = 3'd1,
    CMD_DISPLAY = 3'd2,
    CMD_INSERT  = 3'd3,
    CMD_DELETE  = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_e;

endpackage

`default_nettype wire

@@ rtl/positional_insert_delete_array.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Channel   Handshake                 Payload
// input     in_valid_i / in_ready_o   command_i, position_i, value_i
// output    out_valid_o / out_ready_i element_o, status_o, count_after_o, last_o
//
// Clear, append and every error answer in the cycle after the word is taken.
// Insert moves the elements from the position up a slot each through the
// one-port-each RAM, then writes the value; delete moves those above it down.
// Display reads one element per RAM access, then captures and returns each word.
// Reset empties the list; the element RAM itself is not cleared.
// A result is held until it is taken, and no new word is taken meanwhile.

module positional_insert_delete_array (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [pida_pkg::CMD_W-1:0]              command_i,
  input  logic [pida_pkg::POS_W-1:0]              position_i,
  input  logic signed [pida_pkg::DATA_W-1:0]      value_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [pida_pkg::DATA_W-1:0]      element_o,
  output logic [pida_pkg::STATUS_W-1:0]           status_o,
  output logic [pida_pkg::COUNT_OUT_W-1:0]        count_after_o,
  output logic                                    last_o
);

  localparam int unsigned IDX_W  = pida_pkg::IDX_W;
  localparam int unsigned CNT_W  = pida_pkg::CNT_W;
  localparam int unsigned DATA_W = pida_pkg::DATA_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_DOWN,
    S_INS_WR,
    S_DISP_RD,
    S_DISP_CAP,
    S_RESP
  } state_e;

  state_e                 state_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [IDX_W-1:0]       idx_q;
  logic [IDX_W-1:0]       wa_q;
  logic [IDX_W-1:0]       pos_q;
  logic [IDX_W-1:0]       disp_end_q;
  logic [DATA_W-1:0]      val_q;
  logic                   pend_q;
  logic                   rd_done_q;
  logic                   cap_q;
  logic                   first_q;
  logic                   disp_more_q;

  logic                   out_valid_q;
  logic [DATA_W-1:0]      elem_q;
  pida_pkg::status_e      status_q;
  logic [CNT_W-1:0]       ocnt_q;
  logic                   last_q;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [DATA_W-1:0]      ram_wdata;
  logic                   ram_re;
  logic [IDX_W-1:0]       ram_raddr;
  logic [DATA_W-1:0]      ram_rdata;

  logic                   in_fire;
  logic                   is_full;
  logic                   is_empty;
  logic                   pos_gt_cnt;
  logic                   pos_ge_cnt;
  logic                   ins_at_end;
  logic [IDX_W-1:0]       pos_idx;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_full    = (cnt_q == CNT_W'(pida_pkg::DEPTH));
  assign is_empty   = (cnt_q == '0);
  assign pos_gt_cnt = (int'(position_i) > int'(cnt_q));
  assign pos_ge_cnt = (int'(position_i) >= int'(cnt_q));
  assign ins_at_end = (int'(position_i) == int'(cnt_q));
  assign pos_idx    = IDX_W'(position_i);

  // RAM port steering. Appends and inserts at the end write straight from idle.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && !is_full &&
            ((command_i == pida_pkg::CMD_APPEND) ||
             ((command_i == pida_pkg::CMD_INSERT) && ins_at_end))) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_q[IDX_W-1:0];
          ram_wdata = value_i;
        end
      end
      S_UP: begin
        ram_re    = !rd_done_q;
        ram_we    = pend_q;
        ram_waddr = wa_q;
        ram_wdata = ram_rdata;
      end
      S_DOWN: begin
        ram_re    = !rd_done_q;
        ram_we    = pend_q && !cap_q;
        ram_waddr = wa_q;
        ram_wdata = ram_rdata;
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = val_q;
      end
      S_DISP_RD: begin
        ram_re = 1'b1;
      end
      S_DISP_CAP, S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  pida_ram #(
    .WIDTH (DATA_W),
    .DEPTH (pida_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      wa_q        <= '0;
      pos_q       <= '0;
      disp_end_q  <= '0;
      val_q       <= '0;
      pend_q      <= 1'b0;
      rd_done_q   <= 1'b0;
      cap_q       <= 1'b0;
      first_q     <= 1'b0;
      disp_more_q <= 1'b0;
      out_valid_q <= 1'b0;
      elem_q      <= '0;
      status_q    <= pida_pkg::STAT_OK;
      ocnt_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            elem_q      <= '0;
            last_q      <= 1'b1;
            ocnt_q      <= cnt_q;
            disp_more_q <= 1'b0;
            unique case (command_i)
              pida_pkg::CMD_CLEAR: begin
                cnt_q       <= '0;
                ocnt_q      <= '0;
                status_q    <= pida_pkg::STAT_OK;
                out_valid_q <= 1'b1;
                state_q     <= S_RESP;
              end
              pida_pkg::CMD_APPEND: begin
                out_valid_q <= 1'b1;
                state_q     <= S_RESP;
                if (is_full) begin
                  status_q <= pida_pkg::STAT_FULL;
                end else begin
                  cnt_q    <= cnt_q + CNT_W'(1);
                  ocnt_q   <= cnt_q + CNT_W'(1);
                  status_q <= pida_pkg::STAT_OK;
                end
              end
              pida_pkg::CMD_DISPLAY: begin
                if (is_empty) begin
                  status_q    <= pida_pkg::STAT_EMPTY;
                  out_valid_q <= 1'b1;
                  state_q     <= S_RESP;
                end else begin
                  idx_q <= '0;
                  if (int'(cnt_q) > int'(pida_pkg::MAX_RESULTS)) begin
                    disp_end_q <= IDX_W'(pida_pkg::MAX_RESULTS - 1);
                  end else begin
                    disp_end_q <= IDX_W'(cnt_q - CNT_W'(1));
                  end
                  state_q <= S_DISP_RD;
                end
              end
              pida_pkg::CMD_INSERT: begin
                if (is_full) begin
                  status_q    <= pida_pkg::STAT_FULL;
                  out_valid_q <= 1'b1;
                  state_q     <= S_RESP;
                end else if (pos_gt_cnt) begin
                  status_q    <= pida_pkg::STAT_BADPOS;
                  out_valid_q <= 1'b1;
                  state_q     <= S_RESP;
                end else if (ins_at_end) begin
                  cnt_q       <= cnt_q + CNT_W'(1);
                  ocnt_q      <= cnt_q + CNT_W'(1);
                  status_q    <= pida_pkg::STAT_OK;
                  out_valid_q <= 1'b1;
                  state_q     <= S_RESP;
                end else begin
                  idx_q     <= IDX_W'(cnt_q - CNT_W'(1));
                  pos_q     <= pos_idx;
                  val_q     <= value_i;
                  pend_q    <= 1'b0;
                  rd_done_q <= 1'b0;
                  state_q   <= S_UP;
                end
              end
              pida_pkg::CMD_DELETE: begin
                if (is_empty) begin
                  status_q    <= pida_pkg::STAT_EMPTY;
                  out_valid_q <= 1'b1;
                  state_q     <= S_RESP;
                end else if (pos_ge_cnt) begin
                  status_q    <= pida_pkg::STAT_BADPOS;
                  out_valid_q <= 1'b1;
                  state_q     <= S_RESP;
                end else begin
                  idx_q     <= pos_idx;
                  pend_q    <= 1'b0;
                  rd_done_q <= 1'b0;
                  cap_q     <= 1'b0;
                  first_q   <= 1'b1;
                  state_q   <= S_DOWN;
                end
              end
              default: begin
                // Unknown commands are dropped without a result.
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_UP: begin
          // Read one element below, write the one read a cycle ago one slot up.
          pend_q <= !rd_done_q;
          wa_q   <= idx_q + IDX_W'(1);
          if (!rd_done_q) begin
            if (idx_q == pos_q) begin
              rd_done_q <= 1'b1;
            end else begin
              idx_q <= idx_q - IDX_W'(1);
            end
          end else begin
            state_q <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          cnt_q       <= cnt_q + CNT_W'(1);
          ocnt_q      <= cnt_q + CNT_W'(1);
          status_q    <= pida_pkg::STAT_OK;
          out_valid_q <= 1'b1;
          state_q     <= S_RESP;
        end
        S_DOWN: begin
          // The first word read is the removed element; the rest move down a slot.
          pend_q <= !rd_done_q;
          cap_q  <= !rd_done_q && first_q;
          wa_q   <= idx_q - IDX_W'(1);
          if (!rd_done_q) begin
            first_q <= 1'b0;
            if (CNT_W'(idx_q) + CNT_W'(1) == cnt_q) begin
              rd_done_q <= 1'b1;
            end else begin
              idx_q <= idx_q + IDX_W'(1);
            end
          end
          if (pend_q && cap_q) begin
            elem_q <= ram_rdata;
          end
          if (rd_done_q) begin
            cnt_q       <= cnt_q - CNT_W'(1);
            ocnt_q      <= cnt_q - CNT_W'(1);
            status_q    <= pida_pkg::STAT_OK;
            out_valid_q <= 1'b1;
            state_q     <= S_RESP;
          end
        end
        S_DISP_RD: begin
          state_q <= S_DISP_CAP;
        end
        S_DISP_CAP: begin
          elem_q      <= ram_rdata;
          status_q    <= pida_pkg::STAT_OK;
          ocnt_q      <= cnt_q;
          last_q      <= (idx_q == disp_end_q);
          disp_more_q <= (idx_q != disp_end_q);
          out_valid_q <= 1'b1;
          state_q     <= S_RESP;
        end
        S_RESP: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (disp_more_q) begin
              idx_q   <= idx_q + IDX_W'(1);
              state_q <= S_DISP_RD;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign element_o     = elem_q;
  assign status_o      = status_q;
  assign count_after_o = pida_pkg::COUNT_OUT_W'(ocnt_q);
  assign last_o        = last_q;

  `ASSERT_IMPLIES(a_cnt_range, clk_i, rst_ni, 1'b1, int'(cnt_q) <= int'(pida_pkg::DEPTH))
  `ASSERT_IMPLIES(a_no_take_while_busy, clk_i, rst_ni, out_valid_q, !in_ready_o)
  `ASSERT_IMPLIES(a_no_write_unless_busy, clk_i, rst_ni, state_q == S_RESP, !ram_we)
  `ASSERT_NEXT(a_clear_empties, clk_i, rst_ni, in_fire && (command_i == pida_pkg::CMD_CLEAR), cnt_q == '0)
  `ASSERT_IMPLIES(a_more_not_last, clk_i, rst_ni, out_valid_q && disp_more_q, !last_q)

endmodule

`default_nettype wire

@@ rtl/pida_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pida_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import pida_pkg::*;

  localparam int CMD_FIRST_UNUSED = 5;
  localparam int CMD_LAST_UNUSED  = 7;
  localparam int CYCLE_LIMIT      = 600000;
  localparam int DRAIN_CYCLES     = 120;
  localparam int HOLD_CYCLES      = 300;
  localparam int MAX_REPORTS      = 100;

  typedef struct {
    logic signed [DATA_W-1:0]   element;
    status_e                    status;
    logic [COUNT_OUT_W-1:0]     count_after;
    logic                       last;
  } list_result_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic [CMD_W-1:0]               command_i = '0;
  logic [POS_W-1:0]               position_i = '0;
  logic signed [DATA_W-1:0]       value_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic signed [DATA_W-1:0]       element_o;
  logic [STATUS_W-1:0]            status_o;
  logic [COUNT_OUT_W-1:0]         count_after_o;
  logic                           last_o;

  // Shadow copy of the list, updated when a word is accepted.
  logic signed [DATA_W-1:0] list_mem [DEPTH];
  int                       list_count = 0;
  list_result_t             pending_results[$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  bit  gaps_enabled = 1'b1;

  positional_insert_delete_array uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .element_o     (element_o),
    .status_o      (status_o),
    .count_after_o (count_after_o),
    .last_o        (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (error_count < MAX_REPORTS)
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  task automatic queue_result(input logic signed [DATA_W-1:0] elem, input status_e st,
                              input logic is_last);
    list_result_t r;
    r.element     = elem;
    r.status      = st;
    r.count_after = list_count[COUNT_OUT_W-1:0];
    r.last        = is_last;
    pending_results.push_back(r);
  endtask

  task automatic predict_list_op(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                 input logic signed [DATA_W-1:0] val);
    int k;
    int n;
    logic signed [DATA_W-1:0] removed;
    case (cmd)
      CMD_CLEAR: begin
        list_count = 0;
        queue_result('0, STAT_OK, 1'b1);
      end
      CMD_APPEND: begin
        if (list_count >= DEPTH) begin
          queue_result('0, STAT_FULL, 1'b1);
        end else begin
          list_mem[list_count] = val;
          list_count++;
          queue_result('0, STAT_OK, 1'b1);
        end
      end
      CMD_DISPLAY: begin
        if (list_count == 0) begin
          queue_result('0, STAT_EMPTY, 1'b1);
        end else begin
          n = (list_count < MAX_RESULTS) ? list_count : MAX_RESULTS;
          for (k = 0; k < n; k++)
            queue_result(list_mem[k], STAT_OK, k + 1 == n);
        end
      end
      CMD_INSERT: begin
        // A full list is reported before the position is looked at.
        if (list_count >= DEPTH) begin
          queue_result('0, STAT_FULL, 1'b1);
        end else if (pos > list_count) begin
          queue_result('0, STAT_BADPOS, 1'b1);
        end else begin
          for (k = list_count; k > pos; k--)
            list_mem[k] = list_mem[k-1];
          list_mem[pos] = val;
          list_count++;
          queue_result('0, STAT_OK, 1'b1);
        end
      end
      CMD_DELETE: begin
        if (list_count == 0) begin
          queue_result('0, STAT_EMPTY, 1'b1);
        end else if (pos >= list_count) begin
          queue_result('0, STAT_BADPOS, 1'b1);
        end else begin
          removed = list_mem[pos];
          for (k = pos; k + 1 < list_count; k++)
            list_mem[k] = list_mem[k+1];
          list_count--;
          queue_result(removed, STAT_OK, 1'b1);
        end
      end
      default: begin
      end
    endcase
  endtask

  // Valid is only lowered when a gap is taken, so it never drops and rises in one step.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                           input logic signed [DATA_W-1:0] val);
    int gap;
    gap = (gaps_enabled && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    predict_list_op(cmd, pos, val);
  endtask

  task automatic pick_random_word(output logic [CMD_W-1:0] cmd, output logic [POS_W-1:0] pos,
                                  output logic signed [DATA_W-1:0] val);
    int r;
    int top;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 15))
      0: val = 32'sh7fffffff;
      1: val = 32'sh80000000;
      default: val = $urandom;
    endcase
    pos = POS_W'($urandom_range(0, 15));
    if (r < 4) begin
      cmd = CMD_CLEAR;
    end else if (r < 8) begin
      cmd = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
    end else if (r < 20) begin
      cmd = CMD_DISPLAY;
    end else if ($urandom_range(0, DEPTH + 1) > list_count) begin
      // Growth gets rarer as the list fills, so both ends are reached now and then.
      if ($urandom_range(0, 1) == 1) begin
        cmd = CMD_APPEND;
      end else begin
        cmd = CMD_INSERT;
        top = (list_count > 15) ? 15 : list_count;
        if ($urandom_range(0, 6) != 0)
          pos = POS_W'($urandom_range(0, top));
      end
    end else begin
      cmd = CMD_DELETE;
      if (list_count > 0 && $urandom_range(0, 6) != 0)
        pos = POS_W'($urandom_range(0, list_count - 1));
    end
  endtask

  task automatic send_random_words(input int n);
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    repeat (n) begin
      pick_random_word(cmd, pos, val);
      send_word(cmd, pos, val);
    end
  endtask

  // Receiver: a requested hold takes priority over random stall bursts.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (gaps_enabled && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(1, 19) - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, element", element_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (element_o !== want.element)
          report_mismatch("element", element_o, want.element);
        if (status_o !== want.status)
          report_mismatch("status", status_o, want.status);
        if (count_after_o !== want.count_after)
          report_mismatch("count_after", count_after_o, want.count_after);
        if (last_o !== want.last)
          report_mismatch("last", last_o, want.last);
      end
    end
  end

  task automatic test_directed_edges();
    int k;
    send_word(CMD_CLEAR, 4'd0, 32'sd0);
    send_word(CMD_DISPLAY, 4'd0, 32'sd0);
    send_word(CMD_DELETE, 4'd0, 32'sd0);
    send_word(CMD_INSERT, 4'd15, 32'sd5);
    send_word(CMD_APPEND, 4'd0, 32'sh7fffffff);
    send_word(CMD_APPEND, 4'd15, 32'sh80000000);
    send_word(CMD_INSERT, 4'd0, -32'sd1);
    // Inserting at the current count behaves as an append.
    send_word(CMD_INSERT, 4'd3, 32'sd0);
    send_word(CMD_INSERT, 4'd5, 32'sd7);
    send_word(CMD_DELETE, 4'd4, 32'sd0);
    send_word(CMD_DELETE, 4'd1, 32'sd0);
    send_word(CMD_DISPLAY, 4'd0, 32'sd0);
    for (k = CMD_FIRST_UNUSED; k <= CMD_LAST_UNUSED; k++)
      send_word(CMD_W'(k), 4'hf, 32'shffffffff);
    send_word(CMD_DELETE, 4'd2, 32'sd0);
    send_word(CMD_DELETE, 4'd0, 32'sd0);
    send_word(CMD_DISPLAY, 4'd0, 32'sd0);
  endtask

  task automatic test_fill_to_full();
    while (list_count < DEPTH)
      send_word(CMD_APPEND, POS_W'($urandom_range(0, 15)), $urandom);
    send_word(CMD_APPEND, 4'd0, 32'sd1);
    send_word(CMD_INSERT, 4'd0, 32'sd2);
    send_word(CMD_INSERT, 4'd15, 32'sd3);
    send_word(CMD_DISPLAY, 4'd0, 32'sd0);
    send_word(CMD_DELETE, 4'd15, 32'sd0);
    send_word(CMD_INSERT, 4'd15, 32'sh80000000);
    send_word(CMD_DELETE, 4'd0, 32'sd0);
    send_word(CMD_DISPLAY, 4'd0, 32'sd0);
    send_word(CMD_CLEAR, 4'd9, 32'sd0);
  endtask

  // The receiver holds off while words keep coming, so the input must stall.
  task automatic test_output_hold();
    @(posedge clk_i);
    hold_left = HOLD_CYCLES;
    send_random_words(20);
  endtask

  task automatic test_random_mix();
    send_random_words(110);
  endtask

  task automatic test_steady_stream();
    gaps_enabled = 1'b0;
    send_random_words(40);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_edges();
    test_fill_to_full();
    test_output_hold();
    test_random_mix();
    test_steady_stream();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pida_pkg.sv
rtl/pida_ram.sv
rtl/positional_insert_delete_array.sv
tb/tb_top.sv
